// ----- rtl/core/pled_pkg.sv -----
// pled_pkg: shared types and constants of the parabola lower envelope block.
// Used by every module under rtl/core except pled_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pled_pkg;

  localparam int POS_W  = 16;
  localparam int COST_W = 32;
  localparam int QPOS_W = 24;
  localparam int DIST_W = 50;
  localparam int BP_W   = 41;
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 17;
  localparam int CNT_W  = 6;
  localparam int ENT_W  = POS_W + COST_W;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SITES = 2'd1,
    ST_ORDER    = 2'd2
  } status_t;

  typedef enum logic {
    REQ_SITE  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    OP_SITE_START = 2'd0,
    OP_SITE_ADD   = 2'd1,
    OP_QUERY      = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SITE_RD,
    S_SITE_GO,
    S_SITE_DIV,
    S_Q_RD,
    S_Q_CMP,
    S_Q_MUL,
    S_Q_ADD,
    S_OUT
  } eng_state_t;

  typedef struct packed {
    logic                     req_type;
    logic                     start_set;
    logic [POS_W-1:0]         site_pos;
    logic signed [COST_W-1:0] site_cost;
    logic [QPOS_W-1:0]        query_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    status_t                  status;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_ent_t;

endpackage
`default_nettype wire

// ----- rtl/core/pled_ram.sv -----
// pled_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module pled_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [$clog2(D)-1:0] wr_addr,
  input  wire logic [W-1:0]         wr_data,
  input  wire logic [$clog2(D)-1:0] rd_addr,
  output logic      [W-1:0]         rd_data
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/pled_front.sv -----
// pled_front: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on pled_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pled_front import pled_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output q_ent_t        q_ent,
  input  wire logic     q_pop
);

  q_ent_t     ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_ent_t     new_ent;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_ent    = ent_r[rp_r];

  always_comb begin
    new_ent.item = in_data;
    priority if (in_data.req_type == REQ_QUERY) begin
      new_ent.op = OP_QUERY;
    end else if (in_data.start_set) begin
      new_ent.op = OP_SITE_START;
    end else begin
      new_ent.op = OP_SITE_ADD;
    end
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_ent;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pled_div.sv -----
// pled_div: radix-2 restoring divider, signed numerator, positive divisor, floor quotient.
// Depends on pled_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pled_div import pled_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  output logic                         done,
  output logic signed [NUM_W:0]        quo
);

  logic             busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NUM_W-1:0] qm_r, qm_nxt, mag;
  logic [DEN_W:0]   trial, tdiff;
  logic             ge;
  logic [NUM_W:0]   qext;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r, qm_r[NUM_W-1]};
  assign tdiff = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign qext  = {1'b0, qm_r};
  assign quo   = neg_r ? $signed(-qext - {{NUM_W{1'b0}}, (rem_r != '0)}) : $signed(qext);
  assign done  = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qm_nxt   = qm_r;
    priority if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[NUM_W-1];
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den;
      qm_nxt   = mag;
    end else if (busy_r) begin
      qm_nxt  = {qm_r[NUM_W-2:0], ge};
      rem_nxt = ge ? tdiff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    qm_r  <= qm_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/pled_engine.sv -----
// pled_engine: back end; builds the envelope stack and walks it for queries.
// Depends on pled_pkg, pled_ram and pled_div.
`timescale 1ns / 1ps
`default_nettype none
module pled_engine import pled_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire q_ent_t q_ent,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  localparam int IW = $clog2(MAX_SITES);
  localparam int BW = $clog2(MAX_SITES + 1);

  eng_state_t        state_r, state_nxt;
  q_ent_t            cur_r, cur_nxt;
  logic [IW-1:0]     k_r, k_nxt, top_r, top_nxt, scan_r, scan_nxt;
  logic              loaded_r, loaded_nxt, err_r, err_nxt;
  logic [POS_W-1:0]  last_pos_r, last_pos_nxt;
  logic [QPOS_W-1:0] lastq_r, lastq_nxt;
  logic signed [DIST_W-1:0] sq_r, sq_nxt, sq_full;
  out_item_t         res_r, res_nxt, out_r, out_nxt;
  logic              ov_r, ov_nxt;

  logic              ent_wr_en, bp_wr_en, div_start, div_done;
  logic [IW-1:0]     ent_wr_addr, ent_rd_addr;
  logic [BW-1:0]     bp_wr_addr, bp_rd_addr;
  logic [ENT_W-1:0]  ent_wr_data, ent_rd_data;
  logic [BP_W-1:0]   bp_wr_data, bp_rd_data;
  logic              site_ph;

  logic [POS_W-1:0]         pv, pos;
  logic signed [COST_W-1:0] fv, cost;
  logic signed [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]         div_den;
  logic signed [NUM_W:0]    div_quo;
  logic signed [BP_W-1:0]   s_val;
  logic [DEN_W-1:0]         psum;
  logic signed [QPOS_W:0]   diff;
  logic [IW:0]              k_inc;

  assign site_ph     = (state_r == S_SITE_RD) || (state_r == S_SITE_GO)
                       || (state_r == S_SITE_DIV);
  assign ent_rd_addr = site_ph ? k_r : scan_r;
  assign bp_rd_addr  = site_ph ? BW'(k_r) : BW'(scan_r) + BW'(1);

  assign pv      = ent_rd_data[ENT_W-1:COST_W];
  assign fv      = $signed(ent_rd_data[COST_W-1:0]);
  assign pos     = cur_r.item.site_pos;
  assign cost    = cur_r.item.site_cost;
  assign div_num = $signed({cost[COST_W-1], cost}) - $signed({fv[COST_W-1], fv});
  assign div_den = {pos - pv, 1'b0};
  assign psum    = {1'b0, pos} + {1'b0, pv};
  assign s_val   = $signed({{(BP_W-NUM_W-1){div_quo[NUM_W]}}, div_quo})
                   + $signed({{(BP_W-DEN_W-7){1'b0}}, psum, 7'b0});
  assign diff    = $signed({1'b0, cur_r.item.query_pos}) - $signed({1'b0, pv, 8'b0});
  assign sq_full = diff * diff;
  assign k_inc   = {1'b0, k_r} + (IW+1)'(1);

  pled_ram #(.W(ENT_W), .D(MAX_SITES)) u_ent_ram (
    .clk(clk), .wr_en(ent_wr_en), .wr_addr(ent_wr_addr), .wr_data(ent_wr_data),
    .rd_addr(ent_rd_addr), .rd_data(ent_rd_data)
  );

  pled_ram #(.W(BP_W), .D(MAX_SITES + 1)) u_bp_ram (
    .clk(clk), .wr_en(bp_wr_en), .wr_addr(bp_wr_addr), .wr_data(bp_wr_data),
    .rd_addr(bp_rd_addr), .rd_data(bp_rd_data)
  );

  pled_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    top_nxt      = top_r;
    scan_nxt     = scan_r;
    loaded_nxt   = loaded_r;
    err_nxt      = err_r;
    last_pos_nxt = last_pos_r;
    lastq_nxt    = lastq_r;
    sq_nxt       = sq_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    ov_nxt       = ov_r && out_stall;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    ent_wr_en    = 1'b0;
    bp_wr_en     = 1'b0;
    ent_wr_addr  = '0;
    bp_wr_addr   = '0;
    ent_wr_data  = {pos, cost};
    bp_wr_data   = s_val;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_ent;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (cur_r.op == OP_QUERY) begin
          if (!loaded_r) begin
            res_nxt.distance = '0;
            res_nxt.status   = ST_NO_SITES;
            state_nxt        = S_OUT;
          end else begin
            if (cur_r.item.query_pos < lastq_r) begin
              err_nxt  = 1'b1;
              scan_nxt = '0;
            end else if (scan_r > top_r) begin
              scan_nxt = '0;
            end
            lastq_nxt = cur_r.item.query_pos;
            state_nxt = S_Q_RD;
          end
        end else if (cur_r.op == OP_SITE_START || !loaded_r) begin
          ent_wr_en    = 1'b1;
          top_nxt      = '0;
          loaded_nxt   = 1'b1;
          last_pos_nxt = pos;
          err_nxt      = 1'b0;
          scan_nxt     = '0;
          lastq_nxt    = '0;
          state_nxt    = S_IDLE;
        end else if (pos <= last_pos_r) begin
          err_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = top_r;
          state_nxt = S_SITE_RD;
        end
      end
      S_SITE_RD: begin
        state_nxt = S_SITE_GO;
      end
      S_SITE_GO: begin
        div_start = 1'b1;
        state_nxt = S_SITE_DIV;
      end
      S_SITE_DIV: begin
        if (div_done) begin
          priority if (k_r != '0 && s_val <= $signed(bp_rd_data)) begin
            k_nxt     = k_r - 1'b1;
            state_nxt = S_SITE_RD;
          end else if (k_inc >= (IW+1)'(MAX_SITES)) begin
            state_nxt = S_IDLE;
          end else begin
            ent_wr_en    = 1'b1;
            bp_wr_en     = 1'b1;
            ent_wr_addr  = k_inc[IW-1:0];
            bp_wr_addr   = BW'(k_inc);
            top_nxt      = k_inc[IW-1:0];
            last_pos_nxt = pos;
            scan_nxt     = '0;
            lastq_nxt    = '0;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_Q_RD: begin
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (scan_r < top_r
            && $signed(bp_rd_data) < $signed({{(BP_W-QPOS_W){1'b0}}, cur_r.item.query_pos}))
        begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_Q_RD;
        end else begin
          state_nxt = S_Q_MUL;
        end
      end
      S_Q_MUL: begin
        sq_nxt    = sq_full;
        state_nxt = S_Q_ADD;
      end
      S_Q_ADD: begin
        res_nxt.distance = sq_r + $signed({{(DIST_W-COST_W-8){fv[COST_W-1]}}, fv, 8'b0});
        res_nxt.status   = err_r ? ST_ORDER : ST_OK;
        state_nxt        = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          out_nxt   = res_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      top_r      <= '0;
      scan_r     <= '0;
      loaded_r   <= 1'b0;
      err_r      <= 1'b0;
      last_pos_r <= '0;
      lastq_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      top_r      <= top_nxt;
      scan_r     <= scan_nxt;
      loaded_r   <= loaded_nxt;
      err_r      <= err_nxt;
      last_pos_r <= last_pos_nxt;
      lastq_r    <= lastq_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/parabola_lower_envelope_dt.sv -----
// parabola_lower_envelope_dt: top level of the 1-D squared-distance transform.
// Depends on pled_pkg, pled_front and pled_engine.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_item_t   (site or query)
//   out     | output    | out_valid/out_stall | out_item_t  (one per query)
//
// Each envelope parabola that a site tests runs the 33-step bit-serial divider once. A query
// reads the breakpoint RAM once for each breakpoint it walks past; a query with no sites
// loaded skips the RAMs and returns status ST_NO_SITES.
// Reset is synchronous, active low, and clears the control state; the envelope RAMs
// are not cleared. A two-entry queue takes beats while the engine works, and the
// result register holds under out_stall.
`timescale 1ns / 1ps
`default_nettype none
module parabola_lower_envelope_dt import pled_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic   q_valid, q_pop;
  q_ent_t q_ent;

  pled_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_ent(q_ent), .q_pop(q_pop)
  );

  pled_engine #(.MAX_SITES(MAX_SITES)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ent(q_ent), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/pled_checker.sv -----
// pled_checker: port-level checks of the top level, bound to every instance.
// Depends on pled_pkg and parabola_lower_envelope_dt.
`timescale 1ns / 1ps
`default_nettype none
module pled_checker import pled_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_nosite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NO_SITES |-> out_data.distance == '0)
    else $error("no-site result carries a distance");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

endmodule

bind parabola_lower_envelope_dt pled_checker u_pled_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
